### rtl/calendar_date_offset_unit_defines.svh
// ----------------------------------------------------------------------------
// Calendar date offset unit - assertion macros
// Assertion forms for the port checker of the date offset unit.
// ----------------------------------------------------------------------------
`ifndef CALENDAR_DATE_OFFSET_UNIT_DEFINES_SVH
`define CALENDAR_DATE_OFFSET_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CDO_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CDO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/cdo_pkg.sv
// ----------------------------------------------------------------------------
// Calendar date offset unit - package
// Widths, status codes, calendar constants and month tables.
// ----------------------------------------------------------------------------
package cdo_pkg;

  localparam int YEAR_WIDTH_DEF   = 14;
  localparam int OFFSET_WIDTH_DEF = 16;

  localparam int MONTH_W   = 4;
  localparam int DAY_W     = 5;
  localparam int WEEKDAY_W = 3;
  localparam int DAYNUM_W  = 23;
  localparam int STATUS_W  = 2;
  localparam int Y400_W    = 9;
  localparam int DIVISOR_W = 7;
  localparam int DN_EXTRA  = 9;   // 366 * 2^YEAR_WIDTH < 2^(YEAR_WIDTH + 9)

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_MONTH = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_DAY   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd3;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  localparam logic [WEEKDAY_W-1:0] WEEKDAY_LAST = 3'd6;

  localparam logic [DIVISOR_W-1:0] CENTURY   = 7'd100;
  localparam logic [DIVISOR_W-1:0] WEEK_DAYS = 7'd7;
  localparam int                   WEEK_BIAS = 6;     // 0000-01-01 is a Saturday
  localparam int                   YEAR_DAYS = 365;
  localparam logic [Y400_W-1:0]    Y400_LAST = 9'd399;

  typedef struct packed {
    logic busy;
    logic out_of_range;
  } cdo_walk_sts_t;

  // Leap test on the year taken modulo 400.
  function automatic logic is_leap400(input logic [Y400_W-1:0] y4);
    is_leap400 = (y4[1:0] == 2'b00) && (y4 != 9'd100) && (y4 != 9'd200)
                 && (y4 != 9'd300);
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    case (m)
      4'd2:                   month_len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: month_len = 5'd30;
      default:                month_len = 5'd31;
    endcase
  endfunction

  // Days in the months before month m of a common year.
  function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
    case (m)
      4'd2:    days_before = 9'd31;
      4'd3:    days_before = 9'd59;
      4'd4:    days_before = 9'd90;
      4'd5:    days_before = 9'd120;
      4'd6:    days_before = 9'd151;
      4'd7:    days_before = 9'd181;
      4'd8:    days_before = 9'd212;
      4'd9:    days_before = 9'd243;
      4'd10:   days_before = 9'd273;
      4'd11:   days_before = 9'd304;
      4'd12:   days_before = 9'd334;
      default: days_before = 9'd0;
    endcase
  endfunction

endpackage

### rtl/cdo_if.sv
// ----------------------------------------------------------------------------
// Calendar date offset unit - channel interfaces
// Valid/ready channels for the date request and the result.
// ----------------------------------------------------------------------------
interface cdo_in_if import cdo_pkg::*; #(
  parameter int YEAR_WIDTH   = YEAR_WIDTH_DEF,
  parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic [YEAR_WIDTH-1:0]          in_year;
  logic [MONTH_W-1:0]             in_month;
  logic [DAY_W-1:0]               in_day;
  logic signed [OFFSET_WIDTH-1:0] day_offset;

  modport source (output valid, in_year, in_month, in_day, day_offset, input ready);
  modport sink   (input valid, in_year, in_month, in_day, day_offset, output ready);
endinterface

interface cdo_out_if import cdo_pkg::*; #(
  parameter int YEAR_WIDTH = YEAR_WIDTH_DEF
);
  logic                  valid;
  logic                  ready;
  logic [YEAR_WIDTH-1:0] out_year;
  logic [MONTH_W-1:0]    out_month;
  logic [DAY_W-1:0]      out_day;
  logic [WEEKDAY_W-1:0]  weekday;
  logic [DAYNUM_W-1:0]   day_number;
  logic [STATUS_W-1:0]   status;

  modport source (output valid, out_year, out_month, out_day, weekday, day_number,
                  status, input ready);
  modport sink   (input valid, out_year, out_month, out_day, weekday, day_number,
                  status, output ready);
endinterface

### rtl/calendar_date_offset_unit.sv
// ----------------------------------------------------------------------------
// Calendar date offset unit - top level
// Checks a Gregorian date, reports its weekday and day number, and moves it
// by a signed day offset.
// ----------------------------------------------------------------------------
// One date is handled at a time: in_chan.ready is high only while the unit is
// idle, and the result stays on out_chan until it is taken. A good date moves
// through these steps in order: the year is split by 100 in the shared
// constant divider, the date is checked and the day number formed, the month
// walker is launched beside the weekday division by 7 in the same divider,
// the walker takes M + 1 steps at one per cycle, where M is the number of
// month boundaries the offset crosses, and the result is then loaded. The
// largest offset, 32767 days, crosses about 1080 months. The next request is
// taken only once the result has been taken and the unit is idle again. A bad
// month or day returns straight from the check with all result fields zero
// but the status. A shifted date whose year leaves 0 .. 2^YEAR_WIDTH-1 gives
// status 3 with the out date zeroed and the weekday and day number still
// valid. Day numbers count from 0000-01-01 (day 0) in the proleptic calendar
// and are reported modulo 2^23.
// ----------------------------------------------------------------------------
module calendar_date_offset_unit import cdo_pkg::*; #(
  parameter int YEAR_WIDTH   = YEAR_WIDTH_DEF,
  parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  cdo_in_if.sink    in_chan,
  cdo_out_if.source out_chan
);

  // Day number width: room for any valid date and for the reported field.
  localparam int DN_W = (YEAR_WIDTH + DN_EXTRA > DAYNUM_W) ? YEAR_WIDTH + DN_EXTRA
                                                          : DAYNUM_W;

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIVY  = 3'd1;  // year / 100 in the divider
  localparam logic [2:0] S_SUM   = 3'd2;  // validate and form the day number
  localparam logic [2:0] S_START = 3'd3;  // launch weekday division and walk
  localparam logic [2:0] S_WAIT  = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0] state_r, state_nxt;

  // Latched request
  logic [YEAR_WIDTH-1:0]          yr_r;
  logic [MONTH_W-1:0]             mon_r;
  logic [DAY_W-1:0]               day_r;
  logic signed [OFFSET_WIDTH-1:0] off_r;
  logic [DN_W-1:0]                dn_r;
  logic [Y400_W-1:0]              y400_r;

  // Result registers
  logic [YEAR_WIDTH-1:0] o_year_r;
  logic [MONTH_W-1:0]    o_month_r;
  logic [DAY_W-1:0]      o_day_r;
  logic [WEEKDAY_W-1:0]  o_wday_r;
  logic [DAYNUM_W-1:0]   o_dnum_r;
  logic [STATUS_W-1:0]   o_stat_r;

  // Shared divider
  logic                 div_start;
  logic [DN_W-1:0]      div_dividend;
  logic                 div_week;
  logic                 div_busy;
  logic [DN_W-1:0]      div_quot;
  logic [DIVISOR_W-1:0] div_rem;

  // Month walker
  logic                  walk_load;
  cdo_walk_sts_t         walk_sts;
  logic [YEAR_WIDTH-1:0] walk_year;
  logic [MONTH_W-1:0]    walk_month;
  logic [DAY_W-1:0]      walk_day;

  // Day number terms
  logic              in_xfer;
  logic              out_xfer;
  logic [DN_W-1:0]   y_ext;
  logic [DN_W-1:0]   c4, c100, c400;
  logic [Y400_W-1:0] y400_c;
  logic              leap_c;
  logic [DAY_W-1:0]  mlen_c;
  logic              feb_adj;
  logic              bad_month;
  logic              bad_day;
  logic [DN_W-1:0]   dn_c;

  assign in_xfer  = in_chan.valid && in_chan.ready;
  assign out_xfer = out_chan.valid && out_chan.ready;

  // Leap counts use ceilings: leap years in 0 .. y-1 are
  // ceil(y/4) - ceil(y/100) + ceil(y/400), year 0 included.
  always_comb begin
    y_ext     = DN_W'(yr_r);
    c4        = (y_ext + DN_W'(3)) >> 2;
    c100      = div_quot + DN_W'(|div_rem);
    c400      = (c100 + DN_W'(3)) >> 2;
    y400_c    = Y400_W'(div_quot[1:0]) * Y400_W'(CENTURY) + Y400_W'(div_rem);
    leap_c    = is_leap400(y400_c);
    mlen_c    = month_len(mon_r, leap_c);
    feb_adj   = (mon_r > MONTH_FEB) && leap_c;
    bad_month = (mon_r == '0) || (mon_r > MONTH_DEC);
    bad_day   = (day_r == '0) || (day_r > mlen_c);
    dn_c      = DN_W'(y_ext * DN_W'(YEAR_DAYS)) + c4 - c100 + c400
                + DN_W'(days_before(mon_r)) + DN_W'(day_r) - DN_W'(1)
                + DN_W'(feb_adj);
  end

  // Divider and walker launch
  always_comb begin
    div_start    = 1'b0;
    div_dividend = DN_W'(in_chan.in_year);
    div_week     = 1'b0;
    walk_load    = 1'b0;
    if ((state_r == S_IDLE) && in_xfer) begin
      div_start = 1'b1;
    end else if (state_r == S_START) begin
      div_start    = 1'b1;
      div_dividend = dn_r + DN_W'(WEEK_BIAS);
      div_week     = 1'b1;
      walk_load    = 1'b1;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_DIVY;
        end
      end
      S_DIVY: begin
        if (!div_busy) begin
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        state_nxt = (bad_month || bad_day) ? S_OUT : S_START;
      end
      S_START: begin
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (!div_busy && !walk_sts.busy) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_xfer) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Request capture and day number
  always_ff @(posedge clk) begin
    if ((state_r == S_IDLE) && in_xfer) begin
      yr_r  <= in_chan.in_year;
      mon_r <= in_chan.in_month;
      day_r <= in_chan.in_day;
      off_r <= in_chan.day_offset;
    end
    if (state_r == S_SUM) begin
      dn_r   <= dn_c;
      y400_r <= y400_c;
    end
  end

  // Result capture: bad dates in the check state, good ones after the walk
  always_ff @(posedge clk) begin
    if ((state_r == S_SUM) && (bad_month || bad_day)) begin
      o_year_r  <= '0;
      o_month_r <= '0;
      o_day_r   <= '0;
      o_wday_r  <= '0;
      o_dnum_r  <= '0;
      o_stat_r  <= bad_month ? ST_BAD_MONTH : ST_BAD_DAY;
    end else if ((state_r == S_WAIT) && !div_busy && !walk_sts.busy) begin
      o_wday_r <= div_rem[WEEKDAY_W-1:0];
      o_dnum_r <= dn_r[DAYNUM_W-1:0];
      if (walk_sts.out_of_range) begin
        o_year_r  <= '0;
        o_month_r <= '0;
        o_day_r   <= '0;
        o_stat_r  <= ST_RANGE;
      end else begin
        o_year_r  <= walk_year;
        o_month_r <= walk_month;
        o_day_r   <= walk_day;
        o_stat_r  <= ST_OK;
      end
    end
  end

  cdo_div #(
    .W (DN_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .by_week  (div_week),
    .busy     (div_busy),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  cdo_walk #(
    .YEAR_WIDTH   (YEAR_WIDTH),
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_walk (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (walk_load),
    .year_i   (yr_r),
    .month_i  (mon_r),
    .day_i    (day_r),
    .y400_i   (y400_r),
    .offset_i (off_r),
    .sts      (walk_sts),
    .year_o   (walk_year),
    .month_o  (walk_month),
    .day_o    (walk_day)
  );

  assign in_chan.ready       = (state_r == S_IDLE);
  assign out_chan.valid      = (state_r == S_OUT);
  assign out_chan.out_year   = o_year_r;
  assign out_chan.out_month  = o_month_r;
  assign out_chan.out_day    = o_day_r;
  assign out_chan.weekday    = o_wday_r;
  assign out_chan.day_number = o_dnum_r;
  assign out_chan.status     = o_stat_r;

endmodule

### rtl/cdo_div.sv
// ----------------------------------------------------------------------------
// Calendar date offset unit - constant divider
// Divides by 100 or by 7 through a scaled reciprocal, quotient then remainder.
// ----------------------------------------------------------------------------
module cdo_div import cdo_pkg::*; #(
  parameter int W = YEAR_WIDTH_DEF + DN_EXTRA
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [W-1:0]         dividend,
  input  logic                 by_week,
  output logic                 busy,
  output logic [W-1:0]         quot,
  output logic [DIVISOR_W-1:0] rem
);

  // Reciprocals scaled so the rounding error stays under 2^-W of the divisor:
  // the upper product bits are the exact quotient for any W-bit dividend.
  localparam int     SH_WEEK  = 3;
  localparam int     SH_CENT  = 7;
  localparam int     RECIP_W  = W + 1;
  localparam int     PROD_W   = 2 * W + SH_CENT;
  localparam longint RCP_WEEK = ((longint'(1) << (W + SH_WEEK)) + longint'(WEEK_DAYS) - 1)
                                / longint'(WEEK_DAYS);
  localparam longint RCP_CENT = ((longint'(1) << (W + SH_CENT)) + longint'(CENTURY) - 1)
                                / longint'(CENTURY);

  logic                 busy_r, busy_nxt;
  logic                 phase_r;
  logic                 week_r;
  logic [W-1:0]         num_r;
  logic [W-1:0]         quot_r;
  logic [DIVISOR_W-1:0] rem_r;
  logic [RECIP_W-1:0]   recip;
  logic [PROD_W-1:0]    prod;
  logic [W-1:0]         quot_c;
  logic [W-1:0]         back;

  // First phase: quotient from the reciprocal product.
  assign recip  = week_r ? RECIP_W'(RCP_WEEK) : RECIP_W'(RCP_CENT);
  assign prod   = PROD_W'(num_r) * PROD_W'(recip);
  assign quot_c = week_r ? prod[W + SH_WEEK +: W] : prod[W + SH_CENT +: W];

  // Second phase: remainder from the registered quotient.
  assign back   = week_r ? quot_r * W'(WEEK_DAYS) : quot_r * W'(CENTURY);

  always_comb begin
    busy_nxt = busy_r;
    if (start) begin
      busy_nxt = 1'b1;
    end else if (busy_r && phase_r) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r   <= dividend;
      week_r  <= by_week;
      phase_r <= 1'b0;
    end else if (busy_r) begin
      if (!phase_r) begin
        quot_r  <= quot_c;
        phase_r <= 1'b1;
      end else begin
        rem_r <= DIVISOR_W'(num_r - back);
      end
    end
  end

  assign busy = busy_r;
  assign quot = quot_r;
  assign rem  = rem_r;

endmodule

### rtl/cdo_walk.sv
// ----------------------------------------------------------------------------
// Calendar date offset unit - month walker
// Moves a date by a day count, one month boundary per cycle.
// ----------------------------------------------------------------------------
module cdo_walk import cdo_pkg::*; #(
  parameter int YEAR_WIDTH   = YEAR_WIDTH_DEF,
  parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           load,
  input  logic [YEAR_WIDTH-1:0]          year_i,
  input  logic [MONTH_W-1:0]             month_i,
  input  logic [DAY_W-1:0]               day_i,
  input  logic [Y400_W-1:0]              y400_i,
  input  logic signed [OFFSET_WIDTH-1:0] offset_i,
  output cdo_walk_sts_t                  sts,
  output logic [YEAR_WIDTH-1:0]          year_o,
  output logic [MONTH_W-1:0]             month_o,
  output logic [DAY_W-1:0]               day_o
);

  localparam logic [YEAR_WIDTH-1:0] YEAR_MAX = {YEAR_WIDTH{1'b1}};

  logic                    busy_r, busy_nxt;
  logic                    oor_r, oor_nxt;
  logic                    fwd_r, fwd_nxt;
  logic [OFFSET_WIDTH-1:0] rem_r, rem_nxt;
  logic [YEAR_WIDTH-1:0]   year_r, year_nxt;
  logic [MONTH_W-1:0]      month_r, month_nxt;
  logic [DAY_W-1:0]        day_r, day_nxt;
  logic [Y400_W-1:0]       y400_r, y400_nxt;
  logic                    leap;
  logic [DAY_W-1:0]        mlen;
  logic [DAY_W-1:0]        room;

  assign leap = is_leap400(y400_r);
  assign mlen = month_len(month_r, leap);
  assign room = mlen - day_r;

  always_comb begin
    busy_nxt  = busy_r;
    oor_nxt   = oor_r;
    fwd_nxt   = fwd_r;
    rem_nxt   = rem_r;
    year_nxt  = year_r;
    month_nxt = month_r;
    day_nxt   = day_r;
    y400_nxt  = y400_r;
    if (load) begin
      busy_nxt  = 1'b1;
      oor_nxt   = 1'b0;
      fwd_nxt   = !offset_i[OFFSET_WIDTH-1];
      rem_nxt   = offset_i[OFFSET_WIDTH-1] ? OFFSET_WIDTH'(-offset_i) : offset_i;
      year_nxt  = year_i;
      month_nxt = month_i;
      day_nxt   = day_i;
      y400_nxt  = y400_i;
    end else if (busy_r) begin
      if (fwd_r) begin
        if (rem_r <= OFFSET_WIDTH'(room)) begin
          // remaining days fit in this month
          day_nxt  = day_r + rem_r[DAY_W-1:0];
          busy_nxt = 1'b0;
        end else begin
          // advance to the first of the next month
          rem_nxt = rem_r - (OFFSET_WIDTH'(room) + OFFSET_WIDTH'(1'b1));
          day_nxt = DAY_W'(1);
          if (month_r == MONTH_DEC) begin
            month_nxt = MONTH_JAN;
            if (year_r == YEAR_MAX) begin
              oor_nxt  = 1'b1;
              busy_nxt = 1'b0;
            end else begin
              year_nxt = year_r + YEAR_WIDTH'(1);
              y400_nxt = (y400_r == Y400_LAST) ? '0 : y400_r + Y400_W'(1);
            end
          end else begin
            month_nxt = month_r + MONTH_W'(1);
          end
        end
      end else begin
        if (rem_r < OFFSET_WIDTH'(day_r)) begin
          day_nxt  = day_r - rem_r[DAY_W-1:0];
          busy_nxt = 1'b0;
        end else begin
          // drop back to the last day of the previous month
          rem_nxt = rem_r - OFFSET_WIDTH'(day_r);
          if (month_r == MONTH_JAN) begin
            month_nxt = MONTH_DEC;
            day_nxt   = month_len(MONTH_DEC, 1'b0);
            if (year_r == '0) begin
              oor_nxt  = 1'b1;
              busy_nxt = 1'b0;
            end else begin
              year_nxt = year_r - YEAR_WIDTH'(1);
              y400_nxt = (y400_r == '0) ? Y400_LAST : y400_r - Y400_W'(1);
            end
          end else begin
            month_nxt = month_r - MONTH_W'(1);
            day_nxt   = month_len(month_r - MONTH_W'(1), leap);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      oor_r  <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      oor_r  <= oor_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fwd_r   <= fwd_nxt;
    rem_r   <= rem_nxt;
    year_r  <= year_nxt;
    month_r <= month_nxt;
    day_r   <= day_nxt;
    y400_r  <= y400_nxt;
  end

  assign sts.busy         = busy_r;
  assign sts.out_of_range = oor_r;
  assign year_o           = year_r;
  assign month_o          = month_r;
  assign day_o            = day_r;

endmodule

### rtl/cdo_checker.sv
// ----------------------------------------------------------------------------
// Calendar date offset unit - port checker
// Watches the channel ports of the top level over time.
// ----------------------------------------------------------------------------
`include "calendar_date_offset_unit_defines.svh"

module cdo_checker import cdo_pkg::*; #(
  parameter int YEAR_WIDTH = YEAR_WIDTH_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [YEAR_WIDTH-1:0] out_year,
  input logic [MONTH_W-1:0]    out_month,
  input logic [DAY_W-1:0]      out_day,
  input logic [WEEKDAY_W-1:0]  weekday,
  input logic [DAYNUM_W-1:0]   day_number,
  input logic [STATUS_W-1:0]   status
);

  logic in_xfer;
  logic bad_date;
  logic out_ok;

  assign in_xfer  = in_valid && in_ready;
  assign bad_date = out_valid && ((status == ST_BAD_MONTH) || (status == ST_BAD_DAY));
  assign out_ok   = out_valid && (status == ST_OK);

  // one transfer in flight: stop taking requests after a transfer
  `CDO_ASSERT_NEXT(a_busy_after_xfer, in_xfer, !in_ready, "request taken while busy")
  `CDO_ASSERT_SAME(a_single_item, in_ready, !out_valid, "ready while result pending")
  `CDO_ASSERT_SAME(a_bad_date_zero, bad_date,
    (out_year == '0) && (out_month == '0) && (out_day == '0) && (weekday == '0)
    && (day_number == '0), "bad date result not zeroed")
  `CDO_ASSERT_SAME(a_ok_date_range, out_ok,
    (out_month >= MONTH_JAN) && (out_month <= MONTH_DEC) && (out_day != '0)
    && (weekday <= WEEKDAY_LAST), "shifted date out of range")
  `CDO_ASSERT_NEXT(a_result_hold, out_valid && !out_ready,
    out_valid && $stable({out_year, out_month, out_day, weekday, day_number, status}),
    "stalled result changed")

endmodule

bind calendar_date_offset_unit cdo_checker #(
  .YEAR_WIDTH (YEAR_WIDTH)
) u_cdo_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .out_year   (out_chan.out_year),
  .out_month  (out_chan.out_month),
  .out_day    (out_chan.out_day),
  .weekday    (out_chan.weekday),
  .day_number (out_chan.day_number),
  .status     (out_chan.status)
);

### dv/tb_calendar_date_offset_unit.sv
// ----------------------------------------------------------------------------
// Calendar date offset unit - testbench
// Sends dates with signed day offsets over the request channel and checks
// every result transfer against a typed answer or a predictor of the block,
// field by field: out date, weekday, day number and status. A short table
// of directed rows comes first, then random dates in four idling phases.
// ----------------------------------------------------------------------------
module tb_calendar_date_offset_unit import cdo_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     YW       = YEAR_WIDTH_DEF;
  localparam int     OW       = OFFSET_WIDTH_DEF;
  localparam longint YEAR_MAX = (longint'(1) << YW) - 1;

  // Day count of one 400-year cycle, and the number of cycles added so that
  // the date split below always works on a nonnegative day count.
  localparam longint CYCLE_DAYS = 146097;
  localparam longint CYCLE_BIAS = 64;

  // Random dates per idling phase; the directed rows run before the first phase.
  localparam int RAND_PER_PHASE = 130;
  localparam int NUM_PHASES     = 4;
  localparam int SRC_IDLE_PCT [NUM_PHASES] = '{0, 48, 0, 24};
  localparam int SNK_STALL_PCT[NUM_PHASES] = '{0, 0, 48, 24};

  // Cycles to hold after the last result so that a stray one would show.
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [YW-1:0]        year;
    logic [MONTH_W-1:0]   month;
    logic [DAY_W-1:0]     day;
    logic signed [OW-1:0] offset;
  } date_req_t;

  typedef struct packed {
    logic [YW-1:0]        year;
    logic [MONTH_W-1:0]   month;
    logic [DAY_W-1:0]     day;
    logic [WEEKDAY_W-1:0] weekday;
    logic [DAYNUM_W-1:0]  day_number;
    logic [STATUS_W-1:0]  status;
  } date_res_t;

  // One row of the directed table: the request, and where the answer can be
  // read off at a glance, the result typed in by hand.
  typedef struct packed {
    date_req_t req;
    logic      typed;
    date_res_t res;
  } date_row_t;

  localparam int NUM_DIR = 25;

  date_row_t dir_rows[NUM_DIR] = '{
    // 0000-01-01 is day 0 and a Saturday
    '{'{0, MONTH_JAN, 1, 0}, 1'b1, '{0, MONTH_JAN, 1, WEEKDAY_LAST, 0, ST_OK}},
    '{'{0, MONTH_JAN, 1, 1}, 1'b1, '{0, MONTH_JAN, 2, WEEKDAY_LAST, 0, ST_OK}},
    // leap day of year 0 is counted
    '{'{0, MONTH_FEB, 29, 0}, 1'b1, '{0, MONTH_FEB, 29, 2, 59, ST_OK}},
    // step back past the first day: year out of range, weekday still valid
    '{'{0, MONTH_JAN, 1, -1}, 1'b1, '{0, 0, 0, WEEKDAY_LAST, 0, ST_RANGE}},
    // bad months, including month and day both bad
    '{'{2000, 0, 15, 5}, 1'b1, '{0, 0, 0, 0, 0, ST_BAD_MONTH}},
    '{'{2000, 13, 1, 0}, 1'b1, '{0, 0, 0, 0, 0, ST_BAD_MONTH}},
    '{'{16383, 15, 31, -32768}, 1'b1, '{0, 0, 0, 0, 0, ST_BAD_MONTH}},
    '{'{0, 0, 0, 0}, 1'b1, '{0, 0, 0, 0, 0, ST_BAD_MONTH}},
    // bad days
    '{'{2001, MONTH_JAN, 0, 0}, 1'b1, '{0, 0, 0, 0, 0, ST_BAD_DAY}},
    '{'{2001, 4, 31, 0}, 1'b1, '{0, 0, 0, 0, 0, ST_BAD_DAY}},
    '{'{1900, MONTH_FEB, 29, 0}, 1'b1, '{0, 0, 0, 0, 0, ST_BAD_DAY}},
    '{'{2000, MONTH_FEB, 30, 7}, 1'b1, '{0, 0, 0, 0, 0, ST_BAD_DAY}},
    // the rest go through the predictor
    '{'{2023, MONTH_JAN, 31, 0}, 1'b0, '0},
    '{'{2000, MONTH_FEB, 29, 365}, 1'b0, '0},
    '{'{1900, MONTH_FEB, 28, 1}, 1'b0, '0},
    '{'{1999, MONTH_DEC, 31, 1}, 1'b0, '0},
    '{'{2100, MONTH_FEB, 28, 1}, 1'b0, '0},
    '{'{2024, 3, 1, -1}, 1'b0, '0},
    '{'{400, MONTH_FEB, 29, -366}, 1'b0, '0},
    '{'{16383, MONTH_DEC, 31, 0}, 1'b0, '0},
    '{'{16383, MONTH_DEC, 31, 1}, 1'b0, '0},
    '{'{16383, 6, 15, -32768}, 1'b0, '0},
    '{'{0, MONTH_JAN, 1, 32767}, 1'b0, '0},
    '{'{0, MONTH_DEC, 31, -366}, 1'b0, '0},
    '{'{10922, 10, 21, 21845}, 1'b0, '0}
  };

  logic clk;
  logic rst_n;

  cdo_in_if  #(.YEAR_WIDTH(YW), .OFFSET_WIDTH(OW)) in_chan ();
  cdo_out_if #(.YEAR_WIDTH(YW))                    out_chan ();

  calendar_date_offset_unit #(
    .YEAR_WIDTH  (YW),
    .OFFSET_WIDTH(OW)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  // Rows queued by the sender, popped in order as the block takes them.
  date_row_t sent_rows_q[$];
  // Results the block still owes, oldest first.
  date_res_t pending_dates_q[$];

  int errors;
  int src_idle_pct;
  int sink_stall_pct;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #60_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int month_days(input longint y, input longint m);
    case (m)
      2:          return (((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0)) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:    return 31;
    endcase
  endfunction

  // Work out the full result of one request: validate the date, count its
  // days from 0000-01-01, then split the shifted day count back into a date.
  function automatic date_res_t predict_shift(input date_req_t q);
    longint    y, m, dy, yy, mm, b, dn, z, era, doe, yoe, doy, mp, ny, nm, nd;
    date_res_t r;
    r  = '0;
    y  = longint'(q.year);
    m  = longint'(q.month);
    dy = longint'(q.day);
    if (q.month < MONTH_JAN || q.month > MONTH_DEC) begin
      r.status = ST_BAD_MONTH;
      return r;
    end
    if (dy < 1 || dy > month_days(y, m)) begin
      r.status = ST_BAD_DAY;
      return r;
    end
    // Count January and February with the year before, as months 13 and 14;
    // the +400 keeps the leap divisions on a nonnegative number.
    yy = (m < 3) ? y - 1 : y;
    mm = (m < 3) ? m + 12 : m;
    b  = yy + 400;
    dn = (yy + 1) * 365 + (b / 4 - 100) - (b / 100 - 4) + (b / 400 - 1)
         + (153 * mm - 457) / 5 + dy - 306;
    r.weekday    = WEEKDAY_W'((dn + 6) % 7);
    r.day_number = DAYNUM_W'(dn);
    // Split the shifted count, taken from 0000-03-01 so that leap days fall
    // at the end of each counted year.
    z   = dn + longint'($signed(q.offset)) - 60 + CYCLE_DAYS * CYCLE_BIAS;
    if (z < 0) z = 0;
    era = z / CYCLE_DAYS;
    doe = z - era * CYCLE_DAYS;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp  = (5 * doy + 2) / 153;
    nd  = doy - (153 * mp + 2) / 5 + 1;
    nm  = (mp < 10) ? mp + 3 : mp - 9;
    ny  = yoe + era * 400 - 400 * CYCLE_BIAS + ((nm <= 2) ? 1 : 0);
    if (ny < 0 || ny > YEAR_MAX) begin
      r.status = ST_RANGE;
      return r;
    end
    r.year   = YW'(ny);
    r.month  = MONTH_W'(nm);
    r.day    = DAY_W'(nd);
    r.status = ST_OK;
    return r;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Present one request after a random idle gap and hold it until the
  // transfer. Valid stays high straight into the next request when there is
  // no gap, so it is never lowered and raised in the same step.
  task automatic send_date(input date_row_t row);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    sent_rows_q.push_back(row);
    in_chan.valid      <= 1'b1;
    in_chan.in_year    <= row.req.year;
    in_chan.in_month   <= row.req.month;
    in_chan.in_day     <= row.req.day;
    in_chan.day_offset <= row.req.offset;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  // Receiver: stall at random at the rate of the current phase.
  always @(posedge clk) begin
    out_chan.ready <= rst_n && ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // On every request transfer, record what the block owes: the typed answer
  // of a directed row, or else the prediction from the values transferred.
  always @(posedge clk) begin : watch_requests
    date_row_t row;
    date_req_t seen;
    if (rst_n && in_chan.valid && in_chan.ready) begin
      row = sent_rows_q.pop_front();
      seen.year   = in_chan.in_year;
      seen.month  = in_chan.in_month;
      seen.day    = in_chan.in_day;
      seen.offset = in_chan.day_offset;
      if (row.typed) pending_dates_q.push_back(row.res);
      else           pending_dates_q.push_back(predict_shift(seen));
    end
  end

  // On every result transfer, check each field against the oldest owed result.
  always @(posedge clk) begin : watch_results
    date_res_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_dates_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %0d-%0d-%0d status %0d",
                 $time, out_chan.out_year, out_chan.out_month, out_chan.out_day,
                 out_chan.status);
      end else begin
        want = pending_dates_q.pop_front();
        check_field("out_year", want.year, out_chan.out_year);
        check_field("out_month", want.month, out_chan.out_month);
        check_field("out_day", want.day, out_chan.out_day);
        check_field("weekday", want.weekday, out_chan.weekday);
        check_field("day_number", want.day_number, out_chan.day_number);
        check_field("status", want.status, out_chan.status);
      end
    end
  end

  initial begin
    date_row_t row;
    int        off;
    int        pick;
    errors         = 0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    rst_n              <= 1'b0;
    in_chan.valid      <= 1'b0;
    in_chan.in_year    <= '0;
    in_chan.in_month   <= '0;
    in_chan.in_day     <= '0;
    in_chan.day_offset <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table, no idling on either side.
    foreach (dir_rows[k]) send_date(dir_rows[k]);

    // Random dates: mostly valid dates with small offsets, some mid-range
    // and full-range offsets, years bunched near both ends now and then so
    // the range check fires, and a tenth of raw noise in month and day.
    for (int p = 0; p < NUM_PHASES; p++) begin
      src_idle_pct   = SRC_IDLE_PCT[p];
      sink_stall_pct = SNK_STALL_PCT[p];
      for (int i = 0; i < RAND_PER_PHASE; i++) begin
        row = '0;
        pick = $urandom_range(0, 9);
        if (pick == 0)      row.req.year = YW'($urandom_range(0, 3));
        else if (pick == 1) row.req.year = YW'($urandom_range(YEAR_MAX - 3, YEAR_MAX));
        else                row.req.year = YW'($urandom_range(0, YEAR_MAX));
        if ($urandom_range(0, 9) == 0) begin
          row.req.month = MONTH_W'($urandom_range(0, 15));
          row.req.day   = DAY_W'($urandom_range(0, 31));
        end else begin
          row.req.month = MONTH_W'($urandom_range(1, 12));
          row.req.day   = DAY_W'($urandom_range(1, month_days(longint'(row.req.year),
                                                              longint'(row.req.month))));
        end
        pick = $urandom_range(0, 19);
        if (pick < 12)      off = int'($urandom_range(0, 800)) - 400;
        else if (pick < 17) off = int'($urandom_range(0, 10000)) - 5000;
        else                off = int'($urandom);
        row.req.offset = OW'(off);
        send_date(row);
      end
    end
    in_chan.valid <= 1'b0;

    // Drain: let the last request be recorded, wait for every owed result,
    // then give stray results time to show.
    @(posedge clk);
    while (pending_dates_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
